>>> rtl/rsfla_pkg.sv
// Shared types and codes for the root slot free-list allocator.
// No dependencies; imported by the top level.
package rsfla_pkg;

   localparam int ID_W    = 16;
   localparam int ADDR_W  = 32;
   localparam int WORD_W  = 2 * ADDR_W;
   localparam int ENTRY_W = WORD_W + 1;
   localparam int GRANT_W = 8;

   typedef logic [1:0]        mode_type;
   typedef logic [1:0]        status_type;
   typedef logic [ID_W-1:0]   id_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [GRANT_W-1:0] grant_type;

   localparam mode_type MODE_ALLOC   = 2'd0;
   localparam mode_type MODE_RELEASE = 2'd1;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BOUNDS    = 2'd1;
   localparam status_type STATUS_NOT_ALLOC = 2'd2;
   localparam status_type STATUS_FULL      = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

>>> rtl/rsfla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rsfla_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/root_slot_free_list_allocator_unit.sv
// Root slot allocator: LIFO free list of slots kept in one synchronous RAM.
// Depends on rsfla_pkg and rsfla_ram.
//
// Usage:
//   Request: drive req_* and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. req_mode selects allocate,
//   release or lookup (code three acts as lookup).
//   Response: rsp_valid is high for exactly one cycle with rsp_status,
//   rsp_granted_slot and the found address; the receiver cannot stall it.
// Timing:
//   The RAM reads the slot entry when the request is accepted (registered
//   read); the execute state checks it and, on allocate or release, writes
//   it and updates the head. The response strobe appears in the cycle after
//   execute, and a new request can be taken in that same cycle, not before.
// Reset:
//   Synchronous, active high. The free list restarts as 0, 1, 2, ... with all
//   slots free. No clearing pass: a fill mark tracks which slots were never
//   touched, and those read as free with link to the next slot.
module root_slot_free_list_allocator_unit #(
   parameter int SLOT_COUNT = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  rsfla_pkg::mode_type     req_mode,
   input  rsfla_pkg::id_type       req_slot_id,
   input  rsfla_pkg::addr_type     req_table_part,
   input  rsfla_pkg::addr_type     req_cell_part,
   output logic                    rsp_valid,
   output rsfla_pkg::status_type   rsp_status,
   output rsfla_pkg::grant_type    rsp_granted_slot,
   output rsfla_pkg::addr_type     rsp_found_table_part,
   output rsfla_pkg::addr_type     rsp_found_cell_part
);

   import rsfla_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOT_COUNT);
   localparam logic [ID_W:0]    ID_LIMIT = (ID_W + 1)'(SLOT_COUNT);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   mode_type  mode_ff;
   id_type    id_ff;
   addr_type  tbl_ff;
   addr_type  cel_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   grant_type  rsp_grant_ff, rsp_grant_in;
   addr_type   rsp_tbl_ff, rsp_tbl_in;
   addr_type   rsp_cel_ff, rsp_cel_in;

   logic               accept;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [WORD_W-1:0] rd_word;
   logic [CNT_W-1:0]  id_ext;
   logic [CNT_W-1:0]  link;
   logic              in_use;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Allocate reads the head entry; release and lookup read the addressed one.
   assign rd_en   = accept;
   assign rd_addr = (req_mode == MODE_ALLOC) ? head_ff[IDX_W-1:0]
                                             : req_slot_id[IDX_W-1:0];

   rsfla_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_word = rd_data[WORD_W-1:0];
   assign id_ext  = {1'b0, id_ff[IDX_W-1:0]};
   // Entries at or above the fill mark were never written: free.
   assign in_use  = rd_data[WORD_W] && (id_ext < fill_ff);

   always_comb begin
      // Untouched head links to the next slot; otherwise clamp a stored link.
      if (head_ff >= fill_ff) begin
         link = head_ff + CNT_W'(1);
      end else if (rd_word > WORD_W'(SLOT_COUNT)) begin
         link = SLOT_END;
      end else begin
         link = rd_word[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      wr_en         = 1'b0;
      wr_addr       = id_ff[IDX_W-1:0];
      wr_data       = {1'b0, WORD_W'(head_ff)};
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_grant_in  = '0;
      rsp_tbl_in    = '0;
      rsp_cel_in    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (mode_ff == MODE_ALLOC) begin
               if (head_ff == SLOT_END) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = head_ff[IDX_W-1:0];
                  wr_data      = {1'b1, tbl_ff, cel_ff};
                  head_in      = link;
                  rsp_grant_in = GRANT_W'(head_ff);
                  if (head_ff >= fill_ff) begin
                     fill_in = head_ff + CNT_W'(1);
                  end
               end
            end else if ({1'b0, id_ff} >= ID_LIMIT) begin
               rsp_status_in = STATUS_BOUNDS;
            end else if (!in_use) begin
               rsp_status_in = STATUS_NOT_ALLOC;
            end else if (mode_ff == MODE_RELEASE) begin
               // Push the slot: it links to the old head.
               wr_en   = 1'b1;
               head_in = id_ext;
            end else begin
               rsp_tbl_in = rd_word[WORD_W-1:ADDR_W];
               rsp_cel_in = rd_word[ADDR_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         id_ff   <= req_slot_id;
         tbl_ff  <= req_table_part;
         cel_ff  <= req_cell_part;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_tbl_ff    <= rsp_tbl_in;
      rsp_cel_ff    <= rsp_cel_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_granted_slot     = rsp_grant_ff;
   assign rsp_found_table_part = rsp_tbl_ff;
   assign rsp_found_cell_part  = rsp_cel_ff;

`ifndef SYNTHESIS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not enter execute");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EXEC))
      else $error("response strobe without an execute cycle");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= SLOT_END) && (fill_ff <= SLOT_END))
      else $error("free head or fill mark beyond the table");

   a_full_means_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL)) |-> (head_ff == SLOT_END))
      else $error("full status while the free list is not empty");

   a_fill_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (fill_ff >= $past(fill_ff)))
      else $error("fill mark moved backward");
`endif

endmodule

>>> dv/root_slot_free_list_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the root slot allocator: random allocate, release and lookup traffic.
// Predicts every response from its own copy of the slot table and free list.
// Depends on rsfla_pkg and root_slot_free_list_allocator_unit.
module root_slot_free_list_allocator_unit_tb;
   import rsfla_pkg::*;

   localparam int unsigned SLOT_COUNT  = 256;
   localparam int unsigned IDX_W       = $clog2(SLOT_COUNT);
   localparam int unsigned STALL_LIMIT = 500;
   localparam int unsigned PRINT_CAP   = 50;

   // Every code other than allocate and release is decoded as lookup, so both codes look up.
   localparam mode_type MODE_LOOKUP     = 2'd2;
   localparam mode_type MODE_LOOKUP_ALT = 2'd3;

   typedef struct {
      mode_type    mode;
      id_type      slot_id;
      addr_type    table_part;
      addr_type    cell_part;
      int unsigned gap;
      bit          hold_until_quiet;
   } slot_req_type;

   typedef struct {
      status_type status;
      grant_type  granted_slot;
      addr_type   found_table_part;
      addr_type   found_cell_part;
   } slot_rsp_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       start          = 1'b0;
   mode_type   req_mode       = MODE_ALLOC;
   id_type     req_slot_id    = '0;
   addr_type   req_table_part = '0;
   addr_type   req_cell_part  = '0;
   logic       busy;
   logic       rsp_valid;
   status_type rsp_status;
   grant_type  rsp_granted_slot;
   addr_type   rsp_found_table_part;
   addr_type   rsp_found_cell_part;

   // Shadow of the block's slot table.
   bit          slot_taken [SLOT_COUNT];
   logic [63:0] slot_word  [SLOT_COUNT];
   int unsigned list_head;
   int unsigned held_count;
   int unsigned held_peak;

   slot_req_type req_backlog [$];
   slot_rsp_type awaited_rsp [$];
   slot_req_type cur_req;
   slot_rsp_type want_rsp;
   bit           have_item     = 1'b0;
   int unsigned  gap_left      = 0;
   bit           launch;
   bit           took;
   int unsigned  req_taken     = 0;
   int unsigned  rsp_seen      = 0;
   int unsigned  idle_cycles   = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  status_tally [4];

   root_slot_free_list_allocator_unit dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_slot_id          (req_slot_id),
      .req_table_part       (req_table_part),
      .req_cell_part        (req_cell_part),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_granted_slot     (rsp_granted_slot),
      .rsp_found_table_part (rsp_found_table_part),
      .rsp_found_cell_part  (rsp_found_cell_part)
   );

   always #1 clock = ~clock;

   function automatic void clear_slot_table();
      for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
         slot_taken[IDX_W'(i)] = 1'b0;
         slot_word[IDX_W'(i)]  = 64'(i + 1);
      end
      list_head  = 0;
      held_count = 0;
   endfunction

   // Apply one transaction to the shadow table and return the response it must produce.
   function automatic slot_rsp_type apply_slot_op(slot_req_type rq);
      slot_rsp_type rs;
      int unsigned  id;
      logic [63:0]  link;
      rs.status           = STATUS_OK;
      rs.granted_slot     = '0;
      rs.found_table_part = '0;
      rs.found_cell_part  = '0;
      id = 32'(rq.slot_id);
      if (rq.mode == MODE_ALLOC) begin
         if (list_head >= SLOT_COUNT) begin
            rs.status = STATUS_FULL;
         end else begin
            link = slot_word[IDX_W'(list_head)];
            rs.granted_slot = grant_type'(list_head);
            slot_taken[IDX_W'(list_head)] = 1'b1;
            slot_word[IDX_W'(list_head)]  = {rq.table_part, rq.cell_part};
            list_head = (link > SLOT_COUNT) ? SLOT_COUNT : 32'(link);
            held_count++;
            if (held_count > held_peak) held_peak = held_count;
         end
      end else if (id >= SLOT_COUNT) begin
         rs.status = STATUS_BOUNDS;
      end else if (!slot_taken[IDX_W'(id)]) begin
         rs.status = STATUS_NOT_ALLOC;
      end else if (rq.mode == MODE_RELEASE) begin
         slot_taken[IDX_W'(id)] = 1'b0;
         slot_word[IDX_W'(id)]  = 64'(list_head);
         list_head = id;
         held_count--;
      end else begin
         rs.found_table_part = slot_word[IDX_W'(id)][63:32];
         rs.found_cell_part  = slot_word[IDX_W'(id)][31:0];
      end
      return rs;
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("[%0t] response %0d: %s got 0x%0h, want 0x%0h", $realtime, rsp_seen, what,
                  got, want);
      mismatch_count++;
   endtask

   function automatic void queue_req(mode_type m, id_type id, addr_type t, addr_type c);
      slot_req_type rq;
      rq.mode             = m;
      rq.slot_id          = id;
      rq.table_part       = t;
      rq.cell_part        = c;
      rq.gap              = $urandom_range(7);
      rq.hold_until_quiet = 1'b0;
      req_backlog.push_back(rq);
   endfunction

   function automatic addr_type draw_addr();
      int unsigned r;
      r = $urandom_range(19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // Draw a transaction; hit_pct steers release and lookup ids toward slots that are held.
   function automatic slot_req_type draw_req(int unsigned alloc_pct, int unsigned release_pct,
                                             int unsigned hit_pct, int unsigned gap_max);
      slot_req_type rq;
      int unsigned  r;
      int unsigned  base;
      int unsigned  pick;
      r = $urandom_range(99);
      if (r < alloc_pct) rq.mode = MODE_ALLOC;
      else if (r < alloc_pct + release_pct) rq.mode = MODE_RELEASE;
      else rq.mode = ($urandom_range(3) == 0) ? MODE_LOOKUP_ALT : MODE_LOOKUP;
      r = $urandom_range(99);
      if (r < hit_pct && held_count != 0) begin
         base = $urandom_range(SLOT_COUNT - 1);
         pick = base;
         for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
            if (slot_taken[IDX_W'((base + k) % SLOT_COUNT)]) begin
               pick = (base + k) % SLOT_COUNT;
               break;
            end
         end
         rq.slot_id = id_type'(pick);
      end else if (r < 92) begin
         rq.slot_id = id_type'($urandom_range(SLOT_COUNT - 1));
      end else begin
         rq.slot_id = id_type'($urandom);
      end
      rq.table_part       = draw_addr();
      rq.cell_part        = draw_addr();
      rq.gap              = $urandom_range(gap_max);
      rq.hold_until_quiet = 1'b0;
      return rq;
   endfunction

   // Keep the backlog short so that drawn ids track the current table contents.
   task automatic run_phase(int unsigned count, int unsigned alloc_pct, int unsigned release_pct,
                            int unsigned hit_pct, int unsigned gap_max, bit quiet_first);
      slot_req_type rq;
      for (int unsigned k = 0; k < count; k++) begin
         while (req_backlog.size() >= 2) @(negedge clock);
         rq = draw_req(alloc_pct, release_pct, hit_pct, gap_max);
         rq.hold_until_quiet = quiet_first && (k == 0);
         req_backlog.push_back(rq);
      end
   endtask

   // Driver: hold start until the transaction is taken, then advance after the drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         have_item = 1'b0;
         gap_left  = 0;
         clear_slot_table();
      end else begin
         took = start && !busy;
         if (took) begin
            awaited_rsp.push_back(apply_slot_op(cur_req));
            req_taken++;
            have_item = 1'b0;
         end
         if (!have_item && req_backlog.size() != 0) begin
            cur_req   = req_backlog.pop_front();
            have_item = 1'b1;
            gap_left  = cur_req.gap;
         end
         launch = 1'b0;
         if (have_item) begin
            if (gap_left > 0) gap_left--;
            else if ((start && !took) || !cur_req.hold_until_quiet || awaited_rsp.size() == 0)
               launch = 1'b1;
         end
         start <= launch;
         if (launch) begin
            req_mode       <= cur_req.mode;
            req_slot_id    <= cur_req.slot_id;
            req_table_part <= cur_req.table_part;
            req_cell_part  <= cur_req.cell_part;
         end
      end
   end

   // Monitor: results cannot be held off, so check each strobe against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid) begin
            rsp_seen++;
            status_tally[rsp_status]++;
            if (awaited_rsp.size() == 0) begin
               flag_mismatch("unexpected response, status", 64'(rsp_status), '0);
            end else begin
               want_rsp = awaited_rsp.pop_front();
               if (rsp_status !== want_rsp.status)
                  flag_mismatch("status", 64'(rsp_status), 64'(want_rsp.status));
               if (rsp_granted_slot !== want_rsp.granted_slot)
                  flag_mismatch("granted_slot", 64'(rsp_granted_slot),
                                64'(want_rsp.granted_slot));
               if (rsp_found_table_part !== want_rsp.found_table_part)
                  flag_mismatch("found_table_part", 64'(rsp_found_table_part),
                                64'(want_rsp.found_table_part));
               if (rsp_found_cell_part !== want_rsp.found_cell_part)
                  flag_mismatch("found_cell_part", 64'(rsp_found_cell_part),
                                64'(want_rsp.found_cell_part));
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Misses on an empty table, then ids past the bounds.
      queue_req(MODE_LOOKUP,      16'd0,      '0, '0);
      queue_req(MODE_RELEASE,     16'd0,      '0, '0);
      queue_req(MODE_LOOKUP,      16'd255,    '0, '0);
      queue_req(MODE_LOOKUP,      16'd256,    '0, '0);
      queue_req(MODE_RELEASE,     16'hFFFF,   '0, '0);
      queue_req(MODE_LOOKUP_ALT,  16'h8000,   '0, '0);
      queue_req(MODE_RELEASE,     16'd256,    '0, '0);
      // Fill a few slots with extreme addresses and read them back.
      queue_req(MODE_ALLOC,       16'hFFFF,   32'hFFFF_FFFF, 32'h0000_0000);
      queue_req(MODE_ALLOC,       16'h0000,   32'h0000_0000, 32'hFFFF_FFFF);
      queue_req(MODE_ALLOC,       16'h1234,   32'h0000_0000, 32'h0000_0000);
      queue_req(MODE_LOOKUP,      16'd0,      '0, '0);
      queue_req(MODE_LOOKUP,      16'd1,      '0, '0);
      queue_req(MODE_LOOKUP_ALT,  16'd2,      '0, '0);
      // Release and reuse: the list is last in, first out.
      queue_req(MODE_RELEASE,     16'd1,      '0, '0);
      queue_req(MODE_LOOKUP,      16'd1,      '0, '0);
      queue_req(MODE_RELEASE,     16'd1,      '0, '0);
      queue_req(MODE_ALLOC,       16'd0,      32'hA5A5_A5A5, 32'h5A5A_5A5A);
      queue_req(MODE_RELEASE,     16'd0,      '0, '0);
      queue_req(MODE_RELEASE,     16'd2,      '0, '0);
      queue_req(MODE_ALLOC,       16'd0,      32'h8000_0001, 32'h7FFF_FFFE);
      queue_req(MODE_ALLOC,       16'd0,      32'h0000_0001, 32'h8000_0000);
      queue_req(MODE_LOOKUP,      16'd255,    '0, '0);

      run_phase(300, 45, 30, 80, 7, 1'b0);
      // Fill until the table runs full, then drain it past empty.
      run_phase(350, 80, 5, 80, 7, 1'b0);
      run_phase(400, 5, 85, 90, 7, 1'b1);
      run_phase(500, 40, 35, 85, 7, 1'b1);

      while (req_backlog.size() != 0 || have_item || start) @(negedge clock);
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Ran %0d transactions, %0d responses; peak %0d of %0d slots held",
               req_taken, rsp_seen, held_peak, SLOT_COUNT);
      $display("Responses by status: ok %0d, out of bounds %0d, not allocated %0d, full %0d",
               status_tally[STATUS_OK], status_tally[STATUS_BOUNDS],
               status_tally[STATUS_NOT_ALLOC], status_tally[STATUS_FULL]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
